>>> hw/rtl/wqd_pkg.sv
// types and constants shared by the work queue dispatcher
package wqd_pkg;

    // command modes
    localparam logic [2:0] MODE_QUEUE    = 3'd0;
    localparam logic [2:0] MODE_ABORT    = 3'd1;
    localparam logic [2:0] MODE_STATUS   = 3'd2;
    localparam logic [2:0] MODE_ENABLE   = 3'd3;
    localparam logic [2:0] MODE_DISABLE  = 3'd4;
    localparam logic [2:0] MODE_TICK     = 3'd5;
    localparam logic [2:0] MODE_DISPATCH = 3'd6;
    localparam logic [2:0] MODE_DETECT   = 3'd7;

    // configuration register index, taken from paddr[2]
    localparam logic CFG_TICKS_PER_WORK = 1'b0;

    localparam logic [7:0] TICKS_PER_WORK_RESET = 8'd25;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] work_id;
    } t_cmd;

    typedef struct packed {
        logic [2:0] state_code;
        logic [2:0] queue_count;
        logic [7:0] current_work_id;
        logic [7:0] hash_ticks;
        logic       accepted;
        logic       dispatched;
        logic [2:0] dispatch_slot;
    } t_result;

endpackage

>>> hw/rtl/work_queue_dispatcher.sv
// work queue dispatcher top level: id ring memory, run state and apb register
//
// usage
//   commands enter on i_cmd (mode, work_id) and are taken when start is high
//   and busy is low. each command transaction produces exactly one result on
//   o_result, shown for one cycle with o_done high. the receiver cannot stall
//   the result; it must take it in that cycle.
// sequencing
//   a command has the ring head read into a register as it is taken; the
//   update then applies it (read-modify-write of the ring and the control
//   registers) and registers its result onto the ports. busy is high from the
//   take until the update, so no new command is taken while one is in flight.
//   the registered read of the id ring memory is what splits take and update.
// configuration, ticks_per_work at byte address 0 of the apb port
//   writes complete in the access cycle (pready is tied high). the user must
//   make them only while idle; the block itself does not enforce this.
// reset
//   synchronous, active low: state idle, ring empty, head 0, tick counter and
//   active id 0, ticks_per_work 25. ring contents are not cleared.
module work_queue_dispatcher #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  wqd_pkg::t_cmd         i_cmd,
    // result channel
    output logic                  o_done,
    output wqd_pkg::t_result      o_result,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // ring index / count width; the count never exceeds depth-1
    localparam int PW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PW:0]   DEPTH_W   = (PW + 1)'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [PW-1:0] FULL_CNT  = PW'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_READY    = 3'd1,
        ST_WORKING  = 3'd2,
        ST_PENDING  = 3'd3,
        ST_DISABLED = 3'd4
    } t_run_state;

    // id ring memory
    logic [7:0]    r_ring [QUEUE_DEPTH];
    logic [7:0]    r_rd_data;

    // control state
    logic          r_busy;
    logic          r_done;
    t_run_state    r_run, n_run;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_count, n_count;
    logic [7:0]    r_tick, n_tick;
    logic [7:0]    r_active, n_active;
    logic [7:0]    r_ticks_cfg;

    // payload registers
    wqd_pkg::t_cmd    r_cmd;
    wqd_pkg::t_result r_result, n_result;

    // update-cycle signals
    logic          take;
    logic          cfg_wr;
    logic          wr_en;
    logic [PW-1:0] tail;
    logic [PW:0]   tail_sum;
    logic [PW-1:0] head_next;
    logic [7:0]    head_id;
    logic [7:0]    tick_inc;
    logic          accepted;
    logic          dispatched;
    logic [PW+2:0] count_ext;
    logic [PW+2:0] slot_ext;

    assign take   = start && !busy;
    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_result = r_result;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == wqd_pkg::CFG_TICKS_PER_WORK);
    assign prdata = (paddr[2] == wqd_pkg::CFG_TICKS_PER_WORK) ? {24'd0, r_ticks_cfg} : 32'd0;

    // tail slot = (head + count) mod depth, the sum stays below twice the depth
    assign tail_sum  = {1'b0, r_head} + {1'b0, r_count};
    assign tail      = (tail_sum >= DEPTH_W) ? PW'(tail_sum - DEPTH_W) : tail_sum[PW-1:0];
    assign head_next = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign tick_inc  = r_tick + 8'd1;

    // an empty ring dispatches the id written in this same update
    assign head_id = (r_cmd.mode == wqd_pkg::MODE_QUEUE && r_count == '0)
                     ? r_cmd.work_id : r_rd_data;

    always_comb begin
        n_run      = r_run;
        n_head     = r_head;
        n_count    = r_count;
        n_tick     = r_tick;
        n_active   = r_active;
        accepted   = 1'b0;
        dispatched = 1'b0;
        wr_en      = 1'b0;
        unique case (r_cmd.mode)
            wqd_pkg::MODE_QUEUE: begin
                if (r_count != FULL_CNT) begin
                    wr_en    = 1'b1;
                    accepted = 1'b1;
                    n_count  = r_count + 1'b1;
                    if (r_run == ST_READY) begin
                        dispatched = 1'b1;
                        n_count    = r_count;
                        n_head     = head_next;
                        n_active   = head_id;
                        n_tick     = 8'd0;
                        n_run      = ST_WORKING;
                    end
                end
            end
            wqd_pkg::MODE_ABORT: begin
                n_count = '0;
                n_head  = '0;
                n_run   = ST_READY;
            end
            wqd_pkg::MODE_STATUS: begin
            end
            wqd_pkg::MODE_ENABLE: begin
                n_run = ST_READY;
            end
            wqd_pkg::MODE_DISABLE: begin
                n_run = ST_DISABLED;
            end
            wqd_pkg::MODE_TICK: begin
                if (r_run == ST_WORKING) begin
                    n_tick = tick_inc;
                    if (tick_inc == r_ticks_cfg) begin
                        n_run = (r_count != '0) ? ST_PENDING : ST_READY;
                    end
                end
            end
            wqd_pkg::MODE_DISPATCH: begin
                if (r_run == ST_PENDING && r_count != '0) begin
                    dispatched = 1'b1;
                    n_count    = r_count - 1'b1;
                    n_head     = head_next;
                    n_active   = head_id;
                    n_tick     = 8'd0;
                    n_run      = ST_WORKING;
                end
            end
            wqd_pkg::MODE_DETECT: begin
                n_run  = ST_READY;
                n_tick = 8'd0;
            end
            default: begin
            end
        endcase

        // fields are 3 bits wide whatever the ring depth
        count_ext = {3'b000, n_count};
        slot_ext  = dispatched ? {3'b000, r_head} : '0;

        n_result.state_code      = n_run;
        n_result.queue_count     = count_ext[2:0];
        n_result.current_work_id = n_active;
        n_result.hash_ticks      = n_tick;
        n_result.accepted        = accepted;
        n_result.dispatched      = dispatched;
        n_result.dispatch_slot   = slot_ext[2:0];
    end

    // ring memory: head read when a command is taken, tail written on update
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_data <= r_ring[r_head];
        end
        if (r_busy && wr_en) begin
            r_ring[tail] <= r_cmd.work_id;
        end
    end

    // control state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_run       <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_tick      <= 8'd0;
            r_active    <= 8'd0;
            r_ticks_cfg <= wqd_pkg::TICKS_PER_WORK_RESET;
        end else begin
            r_done <= 1'b0;
            if (cfg_wr) begin
                r_ticks_cfg <= pwdata[7:0];
            end
            if (take) begin
                r_busy <= 1'b1;
                r_cmd  <= i_cmd;
            end
            if (r_busy) begin
                // apply the command transaction and show its result
                r_busy   <= 1'b0;
                r_done   <= 1'b1;
                r_result <= n_result;
                r_run    <= n_run;
                r_head   <= n_head;
                r_count  <= n_count;
                r_tick   <= n_tick;
                r_active <= n_active;
            end
        end
    end

endmodule

>>> dv/work_queue_dispatcher_tb.sv
// self-checking testbench for the work queue dispatcher: directed and random command streams
module work_queue_dispatcher_tb;

    localparam int DEPTH = 8;
    // well above the slowest correct run of about 2200 commands with gaps
    localparam int CYCLE_LIMIT = 400000;

    // run states as reported in state_code
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_READY    = 3'd1,
        ST_WORKING  = 3'd2,
        ST_PENDING  = 3'd3,
        ST_DISABLED = 3'd4
    } t_run_state;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    logic             busy;
    wqd_pkg::t_cmd    cmd_in  = '0;
    logic             o_done;
    wqd_pkg::t_result o_result;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [2:0]       paddr   = '0;
    logic [31:0]      pwdata  = '0;
    logic [31:0]      prdata;
    logic             pready;

    work_queue_dispatcher #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd_in),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted dispatcher state, kept in step with accepted transactions
    logic [7:0] ring_ids [DEPTH];
    logic [2:0] ring_head = '0;
    int         ring_fill = 0;
    t_run_state run_state = ST_IDLE;
    logic [7:0] tick_cnt = '0;
    logic [7:0] active_work = '0;
    logic [7:0] ticks_per_work = wqd_pkg::TICKS_PER_WORK_RESET;

    wqd_pkg::t_result due_results [$];
    int         mismatches = 0;
    int         cycles = 0;
    // percent chance of a gap before a command, 0 means back to back
    int         idle_pct = 0;

    // pop the ring head into the engine, returns the slot it came from
    function automatic logic [2:0] take_head();
        logic [2:0] slot;
        slot        = ring_head;
        active_work = ring_ids[slot];
        ring_head   = 3'((int'(slot) + 1) % DEPTH);
        tick_cnt    = '0;
        run_state   = ST_WORKING;
        ring_fill--;
        return slot;
    endfunction

    // apply one command to the predicted state and form the result it reports
    function automatic wqd_pkg::t_result predict_result(input wqd_pkg::t_cmd c);
        wqd_pkg::t_result r;
        r = '0;
        case (c.mode)
            wqd_pkg::MODE_QUEUE: begin
                // full ring drops the request
                if (ring_fill < DEPTH - 1) begin
                    ring_ids[3'((int'(ring_head) + ring_fill) % DEPTH)] = c.work_id;
                    ring_fill++;
                    r.accepted = 1'b1;
                    if (run_state == ST_READY) begin
                        r.dispatch_slot = take_head();
                        r.dispatched    = 1'b1;
                    end
                end
            end
            wqd_pkg::MODE_ABORT: begin
                ring_fill = 0;
                ring_head = '0;
                run_state = ST_READY;
            end
            wqd_pkg::MODE_STATUS: ;
            wqd_pkg::MODE_ENABLE:  run_state = ST_READY;
            wqd_pkg::MODE_DISABLE: run_state = ST_DISABLED;
            wqd_pkg::MODE_TICK: begin
                if (run_state == ST_WORKING) begin
                    tick_cnt = tick_cnt + 8'd1;
                    if (tick_cnt == ticks_per_work)
                        run_state = (ring_fill > 0) ? ST_PENDING : ST_READY;
                end
            end
            wqd_pkg::MODE_DISPATCH: begin
                if (run_state == ST_PENDING && ring_fill > 0) begin
                    r.dispatch_slot = take_head();
                    r.dispatched    = 1'b1;
                end
            end
            wqd_pkg::MODE_DETECT: begin
                run_state = ST_READY;
                tick_cnt  = '0;
            end
            default: ;
        endcase
        r.state_code      = run_state;
        r.queue_count     = ring_fill[2:0];
        r.current_work_id = active_work;
        r.hash_ticks      = tick_cnt;
        return r;
    endfunction

    // drive one command and wait until the block takes it
    task automatic send_cmd(input logic [2:0] mode, input logic [7:0] wid);
        wqd_pkg::t_cmd c;
        c.mode    = mode;
        c.work_id = wid;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        cmd_in <= c;
        // busy and start are both pre-edge values here
        do @(posedge i_clk); while (busy);
        due_results.push_back(predict_result(c));
    endtask

    // stop sending and let every outstanding result come back
    task automatic settle();
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // apb write of ticks_per_work: setup cycle, then access until pready
    task automatic write_ticks(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {wqd_pkg::CFG_TICKS_PER_WORK, 2'b00};
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ticks_per_work = v;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // every result is taken at the edge that ends its strobe cycle
    always @(posedge i_clk) begin
        wqd_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, o_result);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("state_code", want.state_code, o_result.state_code);
                check_field("queue_count", want.queue_count, o_result.queue_count);
                check_field("current_work_id", want.current_work_id,
                            o_result.current_work_id);
                check_field("hash_ticks", want.hash_ticks, o_result.hash_ticks);
                check_field("accepted", want.accepted, o_result.accepted);
                check_field("dispatched", want.dispatched, o_result.dispatched);
                check_field("dispatch_slot", want.dispatch_slot, o_result.dispatch_slot);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // edges of every mode from reset, full ring, short work completion
    task automatic test_directed();
        settle();
        write_ticks(8'd2);
        idle_pct = 20;
        send_cmd(wqd_pkg::MODE_STATUS, 8'h00);
        // tick and dispatch are ignored while idle
        send_cmd(wqd_pkg::MODE_TICK, 8'hFF);
        send_cmd(wqd_pkg::MODE_DISPATCH, 8'h00);
        // queue outside ready stores without dispatch, up to a full ring
        send_cmd(wqd_pkg::MODE_QUEUE, 8'h00);
        send_cmd(wqd_pkg::MODE_QUEUE, 8'hFF);
        send_cmd(wqd_pkg::MODE_QUEUE, 8'h55);
        send_cmd(wqd_pkg::MODE_QUEUE, 8'hAA);
        send_cmd(wqd_pkg::MODE_QUEUE, 8'h0F);
        send_cmd(wqd_pkg::MODE_QUEUE, 8'hF0);
        send_cmd(wqd_pkg::MODE_QUEUE, 8'h33);
        // full ring drops, in idle and in ready
        send_cmd(wqd_pkg::MODE_QUEUE, 8'h81);
        send_cmd(wqd_pkg::MODE_ENABLE, 8'h00);
        send_cmd(wqd_pkg::MODE_QUEUE, 8'h7E);
        // dispatch outside pending is ignored
        send_cmd(wqd_pkg::MODE_DISPATCH, 8'h00);
        send_cmd(wqd_pkg::MODE_DISABLE, 8'h00);
        send_cmd(wqd_pkg::MODE_TICK, 8'h00);
        send_cmd(wqd_pkg::MODE_DETECT, 8'h00);
        // abort empties the ring, then queue in ready dispatches at once
        send_cmd(wqd_pkg::MODE_ABORT, 8'h00);
        send_cmd(wqd_pkg::MODE_QUEUE, 8'hC3);
        send_cmd(wqd_pkg::MODE_TICK, 8'h00);
        send_cmd(wqd_pkg::MODE_QUEUE, 8'h3C);
        send_cmd(wqd_pkg::MODE_TICK, 8'h00);
        send_cmd(wqd_pkg::MODE_DISPATCH, 8'h00);
        send_cmd(wqd_pkg::MODE_TICK, 8'h00);
        send_cmd(wqd_pkg::MODE_TICK, 8'h00);
        settle();
    endtask

    // weighted random commands under one ticks_per_work setting
    task automatic test_random_mix(input logic [7:0] tpw, input int count, input bit gaps);
        int pick;
        logic [2:0] mode;
        settle();
        write_ticks(tpw);
        for (int n = 0; n < count; n++) begin
            // alternate stretches with and without gaps
            if (n % 64 == 0)
                idle_pct = (gaps && $urandom_range(0, 2) != 0) ? 30 : 0;
            pick = $urandom_range(0, 99);
            if (pick < 30)      mode = wqd_pkg::MODE_QUEUE;
            else if (pick < 65) mode = wqd_pkg::MODE_TICK;
            else if (pick < 80) mode = wqd_pkg::MODE_DISPATCH;
            else if (pick < 85) mode = wqd_pkg::MODE_STATUS;
            else if (pick < 90) mode = wqd_pkg::MODE_ENABLE;
            else if (pick < 94) mode = wqd_pkg::MODE_ABORT;
            else if (pick < 97) mode = wqd_pkg::MODE_DISABLE;
            else                mode = wqd_pkg::MODE_DETECT;
            send_cmd(mode, 8'($urandom_range(0, 255)));
        end
        settle();
    endtask

    // full-length work at the extreme settings, zero meaning 256 ticks
    task automatic test_long_work(input logic [7:0] tpw);
        int n_ticks;
        settle();
        write_ticks(tpw);
        idle_pct = 15;
        n_ticks = (tpw == 0) ? 256 : tpw;
        send_cmd(wqd_pkg::MODE_ENABLE, 8'h00);
        send_cmd(wqd_pkg::MODE_QUEUE, 8'($urandom_range(0, 255)));
        send_cmd(wqd_pkg::MODE_QUEUE, 8'($urandom_range(0, 255)));
        send_cmd(wqd_pkg::MODE_STATUS, 8'h00);
        // first work runs out with one waiting, so pending
        repeat (n_ticks) send_cmd(wqd_pkg::MODE_TICK, 8'($urandom_range(0, 255)));
        send_cmd(wqd_pkg::MODE_TICK, 8'h00);
        send_cmd(wqd_pkg::MODE_DISPATCH, 8'h00);
        // second work runs out with none waiting, so ready
        repeat (n_ticks) send_cmd(wqd_pkg::MODE_TICK, 8'($urandom_range(0, 255)));
        send_cmd(wqd_pkg::MODE_STATUS, 8'h00);
        settle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(8'd1, 300, 1'b1);
        test_random_mix(8'd3, 300, 1'b1);
        test_random_mix(8'($urandom_range(2, 8)), 300, 1'b1);
        test_long_work(8'd255);
        test_long_work(8'd0);
        // closing stretch back to back
        test_random_mix(8'd4, 200, 1'b0);

        settle();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/wqd_pkg.sv
hw/rtl/work_queue_dispatcher.sv
dv/work_queue_dispatcher_tb.sv
